[design/mbe_pkg.sv]
// ============================================================================
// mbe_pkg
// Shared types and constants of the Mandelbrot escape-time pixel engine.
// ============================================================================
`default_nettype none

package mbe_pkg;

   // Fixed-point format and field widths
   localparam int FRAC_BITS  = 28;
   localparam int COORD_BITS = 12;
   localparam int ITER_BITS  = 16;
   localparam int WORD_BITS  = 32;  // signed Q4.28 coordinate
   localparam int STEP_BITS  = 28;  // unsigned step
   localparam int SUM_BITS   = 64;

   // Datapath widths
   localparam int MAP_BITS = COORD_BITS + STEP_BITS;    // index * step
   localparam int MUL_W    = WORD_BITS + 1;             // multiplier operand
   localparam int PROD_W   = 2 * MUL_W;                 // exact product
   localparam int SHR_W    = PROD_W - FRAC_BITS;        // product after rescale
   localparam int Z_W      = WORD_BITS + 2;             // iterate zx, zy

   // Register port
   localparam int CSR_ADDR_BITS = 5;
   localparam int CSR_DATA_BITS = 32;
   localparam int REG_IDX_BITS  = CSR_ADDR_BITS - 2;

   // Fixed-point constants
   localparam logic signed [SHR_W-1:0] Q_ONE       = SHR_W'(1) <<< FRAC_BITS;
   localparam logic signed [SHR_W-1:0] Q_QUARTER   = Q_ONE >>> 2;
   localparam logic signed [SHR_W-1:0] Q_SIXTEENTH = Q_ONE >>> 4;
   localparam logic signed [SHR_W-1:0] Q_FOUR      = Q_ONE <<< 2;
   localparam logic signed [WORD_BITS-1:0] W_TWO   = WORD_BITS'(Q_ONE <<< 1);
   localparam logic signed [WORD_BITS-1:0] W_MAX   = {1'b0, {(WORD_BITS-1){1'b1}}};
   localparam logic signed [Z_W-1:0] Z_TWO         = Z_W'(Q_ONE <<< 1);

   // Register reset values
   localparam logic [ITER_BITS-1:0]        MAX_ITER_RESET = ITER_BITS'(512);
   localparam logic signed [WORD_BITS-1:0] X_ORIGIN_RESET = -32'sd536870912;
   localparam logic signed [WORD_BITS-1:0] Y_ORIGIN_RESET = -32'sd402653184;
   localparam logic [STEP_BITS-1:0]        X_STEP_RESET   = STEP_BITS'(806112);
   localparam logic [STEP_BITS-1:0]        Y_STEP_RESET   = STEP_BITS'(806112);

   // Register map, byte address = 4 * index
   typedef enum logic [REG_IDX_BITS-1:0] {
      REG_MAX_ITER,
      REG_X_ORIGIN,
      REG_Y_ORIGIN,
      REG_X_STEP,
      REG_Y_STEP
   } reg_index_type;

   typedef struct packed {
      logic [ITER_BITS-1:0]        max_iter;
      logic signed [WORD_BITS-1:0] x_origin;
      logic signed [WORD_BITS-1:0] y_origin;
      logic [STEP_BITS-1:0]        x_step;
      logic [STEP_BITS-1:0]        y_step;
   } cfg_type;

   // Channel words
   typedef struct packed {
      logic [COORD_BITS-1:0] col;
      logic [COORD_BITS-1:0] row;
   } req_word_type;

   typedef struct packed {
      logic [ITER_BITS-1:0] iterations;
      logic                 shortcut;
      logic [SUM_BITS-1:0]  running_sum;
   } rsp_word_type;

   // Controller states
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MAP_MUL,
      ST_MAP_ADD,
      ST_SC_PREP,
      ST_SC_SQ,
      ST_SC_SUM,
      ST_SC_QS,
      ST_SC_CARD,
      ST_ITER,
      ST_DONE
   } state_type;

   // Datapath commands
   typedef enum logic [3:0] {
      OP_NONE,
      OP_LOAD,
      OP_MAP_MUL,
      OP_MAP_ADD,
      OP_SC_PREP,
      OP_SC_SQ,
      OP_SC_SUM,
      OP_SC_QS,
      OP_SC_CARD,
      OP_ITER,
      OP_EMIT
   } dp_op_type;

   typedef struct packed {
      logic stop;      // iteration loop finished this cycle
      logic out_free;  // output register can take a word
   } dp_stat_type;

endpackage

`default_nettype wire

[design/mbe_csr.sv]
// ============================================================================
// mbe_csr
// APB-style configuration registers: iteration limit, origins and steps.
// ============================================================================
`default_nettype none

module mbe_csr (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              csr_psel,
   input  wire logic                              csr_penable,
   input  wire logic                              csr_pwrite,
   input  wire logic [mbe_pkg::CSR_ADDR_BITS-1:0] csr_paddr,
   input  wire logic [mbe_pkg::CSR_DATA_BITS-1:0] csr_pwdata,
   output logic      [mbe_pkg::CSR_DATA_BITS-1:0] csr_prdata,
   output mbe_pkg::cfg_type                       cfg
);
   import mbe_pkg::*;

   cfg_type       cfg_ff, cfg_in;
   reg_index_type idx;
   logic          wr;

   assign idx = reg_index_type'(csr_paddr[CSR_ADDR_BITS-1:2]);
   assign wr  = csr_psel && csr_penable && csr_pwrite;

   // Register writes
   always_comb begin
      cfg_in = cfg_ff;
      if (wr) begin
         unique case (idx)
            REG_MAX_ITER: cfg_in.max_iter = csr_pwdata[ITER_BITS-1:0];
            REG_X_ORIGIN: cfg_in.x_origin = $signed(csr_pwdata[WORD_BITS-1:0]);
            REG_Y_ORIGIN: cfg_in.y_origin = $signed(csr_pwdata[WORD_BITS-1:0]);
            REG_X_STEP:   cfg_in.x_step   = csr_pwdata[STEP_BITS-1:0];
            REG_Y_STEP:   cfg_in.y_step   = csr_pwdata[STEP_BITS-1:0];
            default:      ;  // unmapped address, write dropped
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.max_iter <= MAX_ITER_RESET;
         cfg_ff.x_origin <= X_ORIGIN_RESET;
         cfg_ff.y_origin <= Y_ORIGIN_RESET;
         cfg_ff.x_step   <= X_STEP_RESET;
         cfg_ff.y_step   <= Y_STEP_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Read mux
   always_comb begin
      unique case (idx)
         REG_MAX_ITER: csr_prdata = CSR_DATA_BITS'(cfg_ff.max_iter);
         REG_X_ORIGIN: csr_prdata = CSR_DATA_BITS'(unsigned'(cfg_ff.x_origin));
         REG_Y_ORIGIN: csr_prdata = CSR_DATA_BITS'(unsigned'(cfg_ff.y_origin));
         REG_X_STEP:   csr_prdata = CSR_DATA_BITS'(cfg_ff.x_step);
         REG_Y_STEP:   csr_prdata = CSR_DATA_BITS'(cfg_ff.y_step);
         default:      csr_prdata = '0;
      endcase
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

[design/mbe_ctrl.sv]
// ============================================================================
// mbe_ctrl
// Sequencer: mapping, bulb/cardioid tests, iteration loop, result hand-off.
// ============================================================================
`default_nettype none

module mbe_ctrl (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_valid,
   output logic              req_ready,
   input  wire mbe_pkg::dp_stat_type stat,
   output mbe_pkg::dp_op_type   cmd
);
   import mbe_pkg::*;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state and datapath command
   always_comb begin
      state_in  = state_ff;
      cmd       = OP_NONE;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd      = OP_LOAD;
               state_in = ST_MAP_MUL;
            end
         end
         ST_MAP_MUL: begin
            cmd      = OP_MAP_MUL;
            state_in = ST_MAP_ADD;
         end
         ST_MAP_ADD: begin
            cmd      = OP_MAP_ADD;
            state_in = ST_SC_PREP;
         end
         ST_SC_PREP: begin
            cmd      = OP_SC_PREP;
            state_in = ST_SC_SQ;
         end
         ST_SC_SQ: begin
            cmd      = OP_SC_SQ;
            state_in = ST_SC_SUM;
         end
         ST_SC_SUM: begin
            cmd      = OP_SC_SUM;
            state_in = ST_SC_QS;
         end
         ST_SC_QS: begin
            cmd      = OP_SC_QS;
            state_in = ST_SC_CARD;
         end
         ST_SC_CARD: begin
            cmd      = OP_SC_CARD;
            state_in = ST_ITER;
         end
         ST_ITER: begin
            cmd = OP_ITER;
            if (stat.stop) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            // wait here while the previous word is still unread
            if (stat.out_free) begin
               cmd      = OP_EMIT;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

[design/mbe_dpath.sv]
// ============================================================================
// mbe_dpath
// Datapath: coordinate mapping, shortcut tests and z = z^2 + c on three
// shared signed multipliers, count accumulator and output register.
// ============================================================================
`default_nettype none

module mbe_dpath (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire mbe_pkg::cfg_type     cfg,
   input  wire mbe_pkg::dp_op_type   cmd,
   output mbe_pkg::dp_stat_type stat,
   input  wire mbe_pkg::req_word_type req_data,
   output logic                 rsp_valid,
   input  wire logic            rsp_ready,
   output mbe_pkg::rsp_word_type rsp_data
);
   import mbe_pkg::*;

   localparam int SAT_W = MAP_BITS + 2;

   // origin + index*step, clamped to the signed word range. The origin is
   // at least the word minimum and the product is never negative, so only
   // the upper clamp can trigger.
   function automatic logic signed [WORD_BITS-1:0] map_sat(
      input logic signed [WORD_BITS-1:0] origin,
      input logic [MAP_BITS-1:0]         prod
   );
      logic signed [SAT_W-1:0] v;
      v = SAT_W'(origin) + $signed({2'b00, prod});
      if (v > SAT_W'(W_MAX)) begin
         return W_MAX;
      end
      return $signed(v[WORD_BITS-1:0]);
   endfunction

   // Pixel and mapping
   logic [COORD_BITS-1:0]        col_ff, col_in, row_ff, row_in;
   logic [MAP_BITS-1:0]          prod_x_ff, prod_x_in, prod_y_ff, prod_y_in;
   logic signed [WORD_BITS-1:0]  cx_ff, cx_in, cy_ff, cy_in;
   // Shortcut tests
   logic signed [MUL_W-1:0]      xp_ff, xp_in, xm_ff, xm_in;
   logic                         in_range_ff, in_range_in;
   logic signed [SHR_W-1:0]      y2_ff, y2_in, xp2_ff, xp2_in, xm2_ff, xm2_in;
   logic                         bulb_ff, bulb_in;
   logic signed [MUL_W-1:0]      q_ff, q_in, qs_ff, qs_in;
   logic                         inside_ff, inside_in;
   // Iteration
   logic signed [Z_W-1:0]        zx_ff, zx_in, zy_ff, zy_in;
   logic [ITER_BITS-1:0]         iter_ff, iter_in;
   logic [ITER_BITS-1:0]         res_iter_ff, res_iter_in;
   logic                         res_short_ff, res_short_in;
   // Output side
   logic [SUM_BITS-1:0]          sum_ff, sum_in;
   rsp_word_type                 rsp_data_ff, rsp_data_in;
   logic                         rsp_valid_ff, rsp_valid_in;

   // Shared multipliers
   logic signed [MUL_W-1:0]  mul_a0, mul_b0, mul_a1, mul_b1, mul_a2, mul_b2;
   logic signed [PROD_W-1:0] prod0, prod1, prod2;
   logic signed [SHR_W-1:0]  shr0, shr1, shr2;

   // Iteration status
   logic                    z_big, esc, at_limit, stop;
   logic signed [SHR_W-1:0] sq_sum, nx_wide, ny_wide;

   // Multiplier operand select
   always_comb begin
      mul_a0 = '0;
      mul_b0 = '0;
      mul_a1 = '0;
      mul_b1 = '0;
      mul_a2 = '0;
      mul_b2 = '0;
      unique case (cmd)
         OP_SC_SQ: begin
            mul_a0 = MUL_W'(cy_ff);
            mul_b0 = MUL_W'(cy_ff);
            mul_a1 = xp_ff;
            mul_b1 = xp_ff;
            mul_a2 = xm_ff;
            mul_b2 = xm_ff;
         end
         OP_SC_CARD: begin
            mul_a0 = q_ff;
            mul_b0 = qs_ff;
         end
         OP_ITER: begin
            // exact while |z| <= 2; otherwise the loop stops anyway
            mul_a0 = $signed(zx_ff[MUL_W-1:0]);
            mul_b0 = $signed(zx_ff[MUL_W-1:0]);
            mul_a1 = $signed(zy_ff[MUL_W-1:0]);
            mul_b1 = $signed(zy_ff[MUL_W-1:0]);
            mul_a2 = $signed(zx_ff[MUL_W-1:0]);
            mul_b2 = $signed(zy_ff[MUL_W-1:0]);
         end
         default: ;
      endcase
   end

   // Exact products, rescaled with floor rounding
   assign prod0 = mul_a0 * mul_b0;
   assign prod1 = mul_a1 * mul_b1;
   assign prod2 = mul_a2 * mul_b2;
   assign shr0  = SHR_W'(prod0 >>> FRAC_BITS);
   assign shr1  = SHR_W'(prod1 >>> FRAC_BITS);
   assign shr2  = SHR_W'(prod2 >>> FRAC_BITS);

   // One iteration step: escape tests and next z
   assign z_big    = (zx_ff > Z_TWO) || (zx_ff < -Z_TWO)
                  || (zy_ff > Z_TWO) || (zy_ff < -Z_TWO);
   assign sq_sum   = shr0 + shr1;
   assign esc      = sq_sum > Q_FOUR;
   assign at_limit = iter_ff == cfg.max_iter;
   assign stop     = inside_ff || at_limit || z_big || esc;
   assign nx_wide  = shr0 - shr1 + SHR_W'(cx_ff);
   assign ny_wide  = (shr2 <<< 1) + SHR_W'(cy_ff);

   always_comb begin
      col_in       = col_ff;
      row_in       = row_ff;
      prod_x_in    = prod_x_ff;
      prod_y_in    = prod_y_ff;
      cx_in        = cx_ff;
      cy_in        = cy_ff;
      xp_in        = xp_ff;
      xm_in        = xm_ff;
      in_range_in  = in_range_ff;
      y2_in        = y2_ff;
      xp2_in       = xp2_ff;
      xm2_in       = xm2_ff;
      bulb_in      = bulb_ff;
      q_in         = q_ff;
      qs_in        = qs_ff;
      inside_in    = inside_ff;
      zx_in        = zx_ff;
      zy_in        = zy_ff;
      iter_in      = iter_ff;
      res_iter_in  = res_iter_ff;
      res_short_in = res_short_ff;
      sum_in       = sum_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff;

      // word taken
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (cmd)
         OP_LOAD: begin
            col_in = req_data.col;
            row_in = req_data.row;
         end
         OP_MAP_MUL: begin
            prod_x_in = MAP_BITS'(col_ff) * MAP_BITS'(cfg.x_step);
            prod_y_in = MAP_BITS'(row_ff) * MAP_BITS'(cfg.y_step);
         end
         OP_MAP_ADD: begin
            cx_in = map_sat(cfg.x_origin, prod_x_ff);
            cy_in = map_sat(cfg.y_origin, prod_y_ff);
         end
         OP_SC_PREP: begin
            // shortcut regions lie inside |x| < 2, |y| < 2
            xp_in       = MUL_W'(cx_ff) + MUL_W'(Q_ONE);
            xm_in       = MUL_W'(cx_ff) - MUL_W'(Q_QUARTER);
            in_range_in = (cx_ff > -W_TWO) && (cx_ff < W_TWO)
                       && (cy_ff > -W_TWO) && (cy_ff < W_TWO);
         end
         OP_SC_SQ: begin
            y2_in  = shr0;
            xp2_in = shr1;
            xm2_in = shr2;
         end
         OP_SC_SUM: begin
            // period-2 bulb: (x+1)^2 + y^2 < 1/16
            bulb_in = (xp2_ff + y2_ff) < Q_SIXTEENTH;
            q_in    = MUL_W'(xm2_ff + y2_ff);
         end
         OP_SC_QS: begin
            qs_in = q_ff + xm_ff;
         end
         OP_SC_CARD: begin
            // cardioid: q*(q + x - 1/4) < y^2/4
            inside_in = in_range_ff && (bulb_ff || (shr0 < (y2_ff >>> 2)));
            zx_in     = '0;
            zy_in     = '0;
            iter_in   = '0;
         end
         OP_ITER: begin
            if (stop) begin
               res_iter_in  = inside_ff ? cfg.max_iter : iter_ff;
               res_short_in = inside_ff;
            end else begin
               zx_in   = Z_W'(nx_wide);
               zy_in   = Z_W'(ny_wide);
               iter_in = iter_ff + ITER_BITS'(1);
            end
         end
         OP_EMIT: begin
            sum_in                  = sum_ff + SUM_BITS'(res_iter_ff);
            rsp_data_in.iterations  = res_iter_ff;
            rsp_data_in.shortcut    = res_short_ff;
            rsp_data_in.running_sum = sum_in;
            rsp_valid_in            = 1'b1;
         end
         default: ;
      endcase
   end

   // Control state and running sum
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         sum_ff       <= '0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         sum_ff       <= sum_in;
      end
   end

   // Payload
   always_ff @(posedge clock) begin
      col_ff       <= col_in;
      row_ff       <= row_in;
      prod_x_ff    <= prod_x_in;
      prod_y_ff    <= prod_y_in;
      cx_ff        <= cx_in;
      cy_ff        <= cy_in;
      xp_ff        <= xp_in;
      xm_ff        <= xm_in;
      in_range_ff  <= in_range_in;
      y2_ff        <= y2_in;
      xp2_ff       <= xp2_in;
      xm2_ff       <= xm2_in;
      bulb_ff      <= bulb_in;
      q_ff         <= q_in;
      qs_ff        <= qs_in;
      inside_ff    <= inside_in;
      zx_ff        <= zx_in;
      zy_ff        <= zy_in;
      iter_ff      <= iter_in;
      res_iter_ff  <= res_iter_in;
      res_short_ff <= res_short_in;
      rsp_data_ff  <= rsp_data_in;
   end

   assign stat.stop     = stop;
   assign stat.out_free = !rsp_valid_ff || rsp_ready;
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_data      = rsp_data_ff;

endmodule

`default_nettype wire

[design/mandelbrot_escape_time.sv]
// ============================================================================
// mandelbrot_escape_time
// Escape-time pixel engine with period-2 bulb and main cardioid shortcuts.
// ============================================================================
//
//  Channel  Handshake              Word
//  -------  ---------------------  -----------------------------------------
//  req      req_valid / req_ready  req_word_type {col, row}
//  rsp      rsp_valid / rsp_ready  rsp_word_type {iterations, shortcut,
//                                                 running_sum}
//  csr      APB write/read, pready  5 registers at byte address 4*index
//
//  A pixel runs mapping, shortcut tests and at most max_iter loop steps
//  before the next accept; the loop runs one z = z^2 + c step per cycle
//  on three shared multipliers. A shortcut pixel stops before any step.
//  Reset (synchronous, active high) restores register defaults, clears the
//  running sum, the output valid flag and the sequencer.
//  A stalled result holds in the output register; the next pixel is taken
//  and computed meanwhile, and waits for the register to free before hand-off.
// ============================================================================
`default_nettype none

module mandelbrot_escape_time (
   input  wire logic                              clock,
   input  wire logic                              reset,
   // pixel input
   input  wire logic                              req_valid,
   output logic                                   req_ready,
   input  wire mbe_pkg::req_word_type             req_data,
   // result output
   output logic                                   rsp_valid,
   input  wire logic                              rsp_ready,
   output mbe_pkg::rsp_word_type                  rsp_data,
   // configuration
   input  wire logic                              csr_psel,
   input  wire logic                              csr_penable,
   input  wire logic                              csr_pwrite,
   input  wire logic [mbe_pkg::CSR_ADDR_BITS-1:0] csr_paddr,
   input  wire logic [mbe_pkg::CSR_DATA_BITS-1:0] csr_pwdata,
   output logic      [mbe_pkg::CSR_DATA_BITS-1:0] csr_prdata,
   output logic                                   csr_pready
);
   import mbe_pkg::*;

   cfg_type     cfg;
   dp_op_type   cmd;
   dp_stat_type stat;

   assign csr_pready = 1'b1;

   mbe_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .cfg         (cfg)
   );

   mbe_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   mbe_dpath u_dpath (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .cmd       (cmd),
      .stat      (stat),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire

[design/mbe_checker.sv]
// ============================================================================
// mbe_checker
// Port-level checks: result hold, running sum, count limit, word balance.
// ============================================================================
`default_nettype none

module mbe_checker (
   input wire logic                              clock,
   input wire logic                              reset,
   input wire logic                              req_valid,
   input wire logic                              req_ready,
   input wire logic                              rsp_valid,
   input wire logic                              rsp_ready,
   input wire mbe_pkg::rsp_word_type             rsp_data,
   input wire logic                              csr_psel,
   input wire logic                              csr_penable,
   input wire logic                              csr_pwrite,
   input wire logic [mbe_pkg::CSR_ADDR_BITS-1:0] csr_paddr,
   input wire logic [mbe_pkg::CSR_DATA_BITS-1:0] csr_pwdata
);
   import mbe_pkg::*;

   logic                 req_take, rsp_take, cfg_wr;
   logic [1:0]           pending_ff, pending_in;
   logic [SUM_BITS-1:0]  sum_ff, sum_in;
   logic [ITER_BITS-1:0] max_iter_ff, max_iter_in;

   assign req_take = req_valid && req_ready;
   assign rsp_take = rsp_valid && rsp_ready;
   assign cfg_wr   = csr_psel && csr_penable && csr_pwrite
                  && (csr_paddr[CSR_ADDR_BITS-1:2] == REG_MAX_ITER);

   // Shadow of words in flight, delivered sum and limit
   always_comb begin
      pending_in  = pending_ff + 2'(req_take) - 2'(rsp_take);
      sum_in      = rsp_take ? sum_ff + SUM_BITS'(rsp_data.iterations) : sum_ff;
      max_iter_in = cfg_wr ? csr_pwdata[ITER_BITS-1:0] : max_iter_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff  <= '0;
         sum_ff      <= '0;
         max_iter_ff <= MAX_ITER_RESET;
      end else begin
         pending_ff  <= pending_in;
         sum_ff      <= sum_in;
         max_iter_ff <= max_iter_in;
      end
   end

   // stalled result word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result word changed while stalled");

   // each result carries the sum of all counts delivered so far
   a_running_sum: assert property (@(posedge clock) disable iff (reset)
      rsp_take |-> rsp_data.running_sum == sum_ff + SUM_BITS'(rsp_data.iterations))
      else $error("running sum does not match delivered counts");

   // count bounded by the limit, shortcut counts exactly the limit
   a_count_limit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.iterations <= max_iter_ff)
                 && (!rsp_data.shortcut || rsp_data.iterations == max_iter_ff))
      else $error("iteration count beyond limit");

   // no result without a pixel behind it
   a_no_extra: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> pending_ff != 2'd0)
      else $error("result word without accepted pixel");

   // ready for a pixel only with at most one result outstanding
   a_ready_room: assert property (@(posedge clock) disable iff (reset)
      req_ready |-> pending_ff <= 2'd1)
      else $error("pixel accepted with no room for its result");

endmodule

bind mandelbrot_escape_time mbe_checker u_mbe_checker (.*);

`default_nettype wire

[bench/mandelbrot_escape_time_test.sv]
// ============================================================================
// mandelbrot_escape_time_test
// Self-checking bench for the escape-time pixel engine. A built-in predictor
// maps each pixel, runs the bulb and cardioid tests and the z = z^2 + c loop
// in exact fixed point, and keeps the running sum. Directed pixels cover the
// shortcut regions, saturated coordinates and the iteration limit extremes;
// random windows and limits follow, with random idling on both channels and
// one long hold-off on the result side.
// ============================================================================

module mandelbrot_escape_time_test;
   timeunit 1ns;
   timeprecision 1ps;

   import mbe_pkg::*;

   localparam longint UNIT_Q      = longint'(1) << FRAC_BITS;
   localparam int     IDLE_PCT    = 31;
   localparam int     DRAIN_LIMIT = 300000;
   localparam int     SHOW_ERRORS = 10;

   // DUT connections, inputs driven to known values from time zero
   logic         clock       = 1'b0;
   logic         reset       = 1'b1;
   logic         req_valid   = 1'b0;
   logic         req_ready;
   req_word_type req_data    = '0;
   logic         rsp_valid;
   logic         rsp_ready   = 1'b0;
   rsp_word_type rsp_data;
   logic         csr_psel    = 1'b0;
   logic         csr_penable = 1'b0;
   logic         csr_pwrite  = 1'b0;
   logic [CSR_ADDR_BITS-1:0] csr_paddr  = '0;
   logic [CSR_DATA_BITS-1:0] csr_pwdata = '0;
   logic [CSR_DATA_BITS-1:0] csr_prdata;
   logic         csr_pready;

   // Predictor copy of the registers and the running sum
   int unsigned   iter_limit  = 512;
   longint        re_origin   = -536870912;
   longint        im_origin   = -402653184;
   longint        re_step     = 806112;
   longint        im_step     = 806112;
   logic [63:0]   count_total = '0;

   rsp_word_type  pixel_results_due[$];

   // Bench bookkeeping
   bit  no_idle         = 1'b0;
   int  hold_off_cycles = 0;
   int  error_count     = 0;
   int  pixels_sent     = 0;
   int  results_checked = 0;
   int  shortcut_seen   = 0;
   int  settings_used   = 0;

   mandelbrot_escape_time uut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // 12 ns clock
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // ------------------------------------------------------------------
   // Fixed-point predictor
   // ------------------------------------------------------------------

   // exact product, rescaled with floor rounding
   function automatic longint q_mul(input longint a, input longint b);
      logic signed [127:0] p;
      p = a * b;
      return longint'(p >>> FRAC_BITS);
   endfunction

   // origin + index*step, clamped to the signed 32-bit range
   function automatic longint map_axis(input longint origin, input longint step,
                                       input longint idx);
      longint v;
      v = origin + idx * step;
      if (v > 64'sd2147483647)
         v = 64'sd2147483647;
      if (v < -64'sd2147483648)
         v = -64'sd2147483648;
      return v;
   endfunction

   function automatic bit in_bulb_or_cardioid(input longint x, input longint y);
      longint y2, xp, xm, q;
      // both regions lie well inside |x|,|y| < 2
      if (x >= 2 * UNIT_Q || x <= -2 * UNIT_Q || y >= 2 * UNIT_Q || y <= -2 * UNIT_Q)
         return 1'b0;
      y2 = q_mul(y, y);
      xp = x + UNIT_Q;
      if (q_mul(xp, xp) + y2 < (UNIT_Q >>> 4))
         return 1'b1;
      xm = x - (UNIT_Q >>> 2);
      q  = q_mul(xm, xm) + y2;
      return q_mul(q, q + xm) < (y2 >>> 2);
   endfunction

   // escape count of one pixel; advances the running sum
   function automatic rsp_word_type escape_result(input logic [COORD_BITS-1:0] col,
                                                  input logic [COORD_BITS-1:0] row);
      longint       cx, cy, zx, zy, xx, yy, nx;
      int unsigned  n;
      bit           sc;
      rsp_word_type r;
      cx = map_axis(re_origin, re_step, longint'(col));
      cy = map_axis(im_origin, im_step, longint'(row));
      n  = 0;
      sc = in_bulb_or_cardioid(cx, cy);
      if (sc) begin
         n = iter_limit;
      end else begin
         zx = 0;
         zy = 0;
         while (n < iter_limit) begin
            // large z escapes before squaring
            if (zx > 2 * UNIT_Q || zx < -2 * UNIT_Q || zy > 2 * UNIT_Q || zy < -2 * UNIT_Q)
               break;
            xx = q_mul(zx, zx);
            yy = q_mul(zy, zy);
            if (xx + yy > 4 * UNIT_Q)
               break;
            nx = xx - yy + cx;
            zy = 2 * q_mul(zx, zy) + cy;
            zx = nx;
            n++;
         end
      end
      count_total   = count_total + 64'(n);
      r.iterations  = n[ITER_BITS-1:0];
      r.shortcut    = sc;
      r.running_sum = count_total;
      return r;
   endfunction

   // ------------------------------------------------------------------
   // Channel drivers
   // ------------------------------------------------------------------

   // offer one pixel, predict it once accepted
   task automatic send_pixel(input int col, input int row);
      req_word_type w;
      w.col = col[COORD_BITS-1:0];
      w.row = row[COORD_BITS-1:0];
      while (!no_idle && $urandom_range(99) < IDLE_PCT) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= w;
      @(posedge clock);
      while (!req_ready)
         @(posedge clock);
      pixel_results_due.push_back(escape_result(w.col, w.row));
      pixels_sent++;
   endtask

   // result side: random idling plus a requested hold-off
   initial begin : receiver
      int k;
      forever begin
         @(posedge clock);
         if (hold_off_cycles > 0) begin
            rsp_ready <= 1'b0;
            for (k = 0; k < hold_off_cycles; k++)
               @(posedge clock);
            hold_off_cycles = 0;
         end
         rsp_ready <= no_idle || ($urandom_range(99) >= IDLE_PCT);
      end
   end

   // compare each result word with the oldest prediction
   always @(posedge clock) begin : result_check
      rsp_word_type want;
      if (!reset && rsp_valid === 1'b1 && rsp_ready) begin
         results_checked++;
         if (rsp_data.shortcut === 1'b1)
            shortcut_seen++;
         if (pixel_results_due.size() == 0) begin
            error_count++;
            if (error_count <= SHOW_ERRORS)
               $display("mismatch: unexpected result word iter=%0d sc=%0b sum=%0d",
                        rsp_data.iterations, rsp_data.shortcut, rsp_data.running_sum);
         end else begin
            want = pixel_results_due.pop_front();
            if (rsp_data.iterations !== want.iterations ||
                rsp_data.shortcut !== want.shortcut ||
                rsp_data.running_sum !== want.running_sum) begin
               error_count++;
               if (error_count <= SHOW_ERRORS)
                  $display("mismatch: exp iter=%0d sc=%0b sum=%0d, got iter=%0d sc=%0b sum=%0d",
                           want.iterations, want.shortcut, want.running_sum,
                           rsp_data.iterations, rsp_data.shortcut, rsp_data.running_sum);
            end
         end
      end
   end

   // ------------------------------------------------------------------
   // Register access
   // ------------------------------------------------------------------

   // setup cycle, access cycle, then release
   task automatic write_reg(input reg_index_type idx, input logic [31:0] value);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= CSR_ADDR_BITS'({idx, 2'b00});
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready)
         @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      case (idx)
         REG_MAX_ITER: iter_limit = value[ITER_BITS-1:0];
         REG_X_ORIGIN: re_origin  = longint'($signed(value));
         REG_Y_ORIGIN: im_origin  = longint'($signed(value));
         REG_X_STEP:   re_step    = longint'(value[STEP_BITS-1:0]);
         REG_Y_STEP:   im_step    = longint'(value[STEP_BITS-1:0]);
         default: ;
      endcase
   endtask

   task automatic set_window(input int xo, input int yo, input int unsigned xs,
                             input int unsigned ys);
      write_reg(REG_X_ORIGIN, xo);
      write_reg(REG_Y_ORIGIN, yo);
      write_reg(REG_X_STEP, xs);
      write_reg(REG_Y_STEP, ys);
      settings_used++;
   endtask

   // stop offering pixels and let every predicted word come back
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (pixel_results_due.size() != 0)
         @(posedge clock);
      @(posedge clock);
   endtask

   // ------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------

   // reset window and limit: corners and a couple of interior pixels
   task automatic test_reset_defaults();
      send_pixel(0, 0);
      send_pixel(4095, 4095);
      send_pixel(0, 4095);
      send_pixel(4095, 0);
      send_pixel(333, 500);
      send_pixel(2048, 2048);
   endtask

   // window of 1/256 per pixel from -2-2i: col = (x+2)*256, row = (y+2)*256
   task automatic test_shortcut_regions();
      wait_idle();
      write_reg(REG_MAX_ITER, 300);
      set_window(-2 * 268435456, -2 * 268435456, 1 << 20, 1 << 20);
      send_pixel(256, 512);    // bulb center
      send_pixel(512, 512);    // cardioid center
      send_pixel(576, 512);    // cusp, iterates to the limit
      send_pixel(320, 512);    // bulb/cardioid junction
      send_pixel(128, 512);    // real axis outside both regions
      send_pixel(0, 512);      // c = -2, far point that never escapes
      send_pixel(512, 0);      // c = -2i, far point
      send_pixel(4095, 4095);  // large z after one step
      send_pixel(384, 704);
      send_pixel(460, 630);
   endtask

   // coordinates that clamp at the top of the 32-bit range or sit at its bottom
   task automatic test_coordinate_saturation();
      wait_idle();
      write_reg(REG_MAX_ITER, 1);
      set_window(32'h7FFF_FFFF, 32'h8000_0000, 28'hFFF_FFFF, 0);
      send_pixel(4095, 0);
      send_pixel(0, 4095);
      send_pixel(1, 1);
      wait_idle();
      write_reg(REG_MAX_ITER, 2);
      set_window(32'h8000_0000, 32'h7FFF_FFFF, 28'hFFF_FFFF, 28'hFFF_FFFF);
      send_pixel(4095, 4095);
      send_pixel(0, 0);
   endtask

   // zero limit and the top limit, with zero steps to pin c
   task automatic test_iteration_limits();
      wait_idle();
      write_reg(REG_MAX_ITER, 0);
      set_window(-402653184, 0, 0, 0);         // c = -1.5
      send_pixel(7, 9);
      wait_idle();
      set_window(-268435456, 0, 0, 0);         // c = -1, bulb
      send_pixel(4095, 4095);
      wait_idle();
      write_reg(REG_MAX_ITER, 65535);
      send_pixel(100, 200);
      wait_idle();
      set_window(-402653184, 0, 0, 0);         // full run to the limit
      send_pixel(0, 0);
      wait_idle();
      set_window(268435456, 268435456, 0, 0);  // c = 1+i, quick escape
      send_pixel(3000, 17);
   endtask

   // result side holds off while pixels keep coming
   task automatic test_output_backpressure();
      int i;
      wait_idle();
      write_reg(REG_MAX_ITER, 8);
      set_window(-536870912, -268435456, 1 << 17, 1 << 17);
      hold_off_cycles = 400;
      for (i = 0; i < 20; i++)
         send_pixel($urandom_range(4095), $urandom_range(4095));
   endtask

   // random limits and windows, mostly around the set itself
   task automatic test_random_windows(input int phases, input int per_phase);
      int p, i, pick;
      for (p = 0; p < phases; p++) begin
         wait_idle();
         pick = $urandom_range(9);
         if (pick == 0)
            write_reg(REG_MAX_ITER, 1);
         else if (pick <= 2)
            write_reg(REG_MAX_ITER, $urandom_range(200, 49));
         else
            write_reg(REG_MAX_ITER, $urandom_range(48, 2));
         pick = $urandom_range(9);
         if (pick < 6)
            set_window(-671088640 + int'($urandom_range(536870912)),
                       -335544320 + int'($urandom_range(335544320)),
                       $urandom_range(1 << 17), $urandom_range(1 << 17));
         else if (pick < 9)
            set_window(int'($urandom), int'($urandom),
                       $urandom & 32'h0FFF_FFFF, $urandom & 32'h0FFF_FFFF);
         else
            set_window($urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000,
                       $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000,
                       $urandom_range(1) ? 28'hFFF_FFFF : 0,
                       $urandom_range(1) ? 28'hFFF_FFFF : 0);
         // one phase runs with both sides streaming
         no_idle = (p == 3);
         for (i = 0; i < per_phase; i++)
            send_pixel($urandom_range(4095), $urandom_range(4095));
      end
      no_idle = 1'b0;
   endtask

   // ------------------------------------------------------------------
   // Sequence
   // ------------------------------------------------------------------
   initial begin : main
      int waited;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      settings_used = 1;

      test_reset_defaults();
      test_shortcut_regions();
      test_coordinate_saturation();
      test_iteration_limits();
      test_output_backpressure();
      test_random_windows(14, 80);

      // drain, then give the engine time for any stray word
      req_valid <= 1'b0;
      waited = 0;
      while (pixel_results_due.size() != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      repeat (iter_limit + 20) @(posedge clock);
      if (pixel_results_due.size() != 0) begin
         error_count += pixel_results_due.size();
         $display("mismatch: %0d predicted words never arrived", pixel_results_due.size());
      end

      $display("summary: %0d pixels sent, %0d words checked under %0d window settings",
               pixels_sent, results_checked, settings_used);
      $display("summary: %0d decided by bulb/cardioid test, %0d errors",
               shortcut_seen, error_count);
      if (error_count == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

   // hard stop
   initial begin : watchdog
      #20ms;
      $display("tb: failure");
      $finish;
   end

endmodule
